[rtl/core/ppc_pkg.sv]
package ppc_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_BITS  = 24;
    localparam int MODE_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_ELASTIC   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_INELASTIC = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ADHESION  = 2'd2;

    localparam logic [RAD_BITS-1:0] RAD_MAX = '1;

    // square root: one result bit per stage
    localparam int SQ_OUT_BITS = 34;
    localparam int SQ_IN_BITS  = 2 * SQ_OUT_BITS;
    localparam int SQ_REM_BITS = SQ_OUT_BITS + 3;
    localparam int SQ_LAT      = SQ_OUT_BITS + 1;

    // divider: one quotient bit per stage, saturating to the signed word
    localparam int DIV_DEN_BITS = 34;
    localparam int DIV_Q_BITS   = 33;
    localparam int DIV_NUM_BITS = DIV_DEN_BITS + DIV_Q_BITS;
    localparam int DIV_LAT      = DIV_Q_BITS + 2;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] in_pos_i_x;
        logic signed [WORD_BITS-1:0] in_pos_i_y;
        logic signed [WORD_BITS-1:0] in_vel_i_x;
        logic signed [WORD_BITS-1:0] in_vel_i_y;
        logic        [WORD_BITS-1:0] in_mass_i;
        logic        [RAD_BITS-1:0]  in_radius_i;
        logic signed [WORD_BITS-1:0] in_pos_j_x;
        logic signed [WORD_BITS-1:0] in_pos_j_y;
        logic signed [WORD_BITS-1:0] in_vel_j_x;
        logic signed [WORD_BITS-1:0] in_vel_j_y;
        logic        [WORD_BITS-1:0] in_mass_j;
        logic        [RAD_BITS-1:0]  in_radius_j;
    } pair_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] out_vel_i_x;
        logic signed [WORD_BITS-1:0] out_vel_i_y;
        logic signed [WORD_BITS-1:0] out_vel_j_x;
        logic signed [WORD_BITS-1:0] out_vel_j_y;
        logic signed [WORD_BITS-1:0] out_pos_i_x;
        logic signed [WORD_BITS-1:0] out_pos_i_y;
        logic        [WORD_BITS-1:0] out_mass_i;
        logic        [WORD_BITS-1:0] out_mass_j;
        logic        [RAD_BITS-1:0]  out_radius_i;
        logic        [RAD_BITS-1:0]  out_radius_j;
        logic                        fault;
    } result_t;

endpackage

[rtl/core/ppc_isqrt.sv]
module ppc_isqrt
    import ppc_pkg::*;
(
    input  logic                   clk,
    input  logic [SQ_IN_BITS-1:0]  radicand,
    output logic [SQ_OUT_BITS-1:0] root
);

    logic [SQ_IN_BITS-1:0]  bits_reg [0:SQ_OUT_BITS-1];
    logic [SQ_REM_BITS-1:0] rem_reg  [0:SQ_OUT_BITS];
    logic [SQ_OUT_BITS-1:0] root_reg [0:SQ_OUT_BITS];

    logic [SQ_REM_BITS-1:0] rem_sh     [1:SQ_OUT_BITS];
    logic [SQ_REM_BITS-1:0] trial      [1:SQ_OUT_BITS];
    logic [SQ_REM_BITS-1:0] rem_next   [1:SQ_OUT_BITS];
    logic [SQ_OUT_BITS-1:0] root_next  [1:SQ_OUT_BITS];

    always_comb
    begin
        for (int k = 1; k <= SQ_OUT_BITS; k++)
        begin
            rem_sh[k] = {rem_reg[k-1][SQ_REM_BITS-3:0], bits_reg[k-1][SQ_IN_BITS-1 -: 2]};
            trial[k]  = {1'b0, root_reg[k-1], 2'b01};
            if (rem_sh[k] >= trial[k])
            begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_reg[k-1][SQ_OUT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_reg[k-1][SQ_OUT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg[0] <= radicand;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        for (int k = 1; k < SQ_OUT_BITS; k++)
        begin
            bits_reg[k] <= {bits_reg[k-1][SQ_IN_BITS-3:0], 2'b00};
        end
        for (int k = 1; k <= SQ_OUT_BITS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign root = root_reg[SQ_OUT_BITS];

endmodule

[rtl/core/ppc_div.sv]
module ppc_div
    import ppc_pkg::*;
(
    input  logic                        clk,
    input  logic                        num_neg,
    input  logic [DIV_NUM_BITS-1:0]     num_mag,
    input  logic [DIV_DEN_BITS-1:0]     den,
    output logic signed [WORD_BITS-1:0] quot
);

    logic [DIV_DEN_BITS-1:0] rem_reg  [0:DIV_Q_BITS];
    logic [DIV_Q_BITS-1:0]   bits_reg [0:DIV_Q_BITS-1];
    logic [DIV_Q_BITS-1:0]   q_reg    [0:DIV_Q_BITS];
    logic [DIV_DEN_BITS-1:0] den_reg  [0:DIV_Q_BITS];
    logic [DIV_Q_BITS:0]     neg_reg;
    logic [DIV_Q_BITS:0]     ovf_reg;
    logic signed [WORD_BITS-1:0] quot_reg;
    logic signed [WORD_BITS-1:0] quot_next;

    logic [DIV_DEN_BITS:0]   sh       [1:DIV_Q_BITS];
    logic [DIV_DEN_BITS-1:0] rem_next [1:DIV_Q_BITS];
    logic [DIV_Q_BITS-1:0]   q_next   [1:DIV_Q_BITS];
    logic [DIV_Q_BITS-1:0]   q_lim;
    logic [DIV_Q_BITS-1:0]   q_sat;
    logic                    neg_last;

    always_comb
    begin
        for (int k = 1; k <= DIV_Q_BITS; k++)
        begin
            sh[k] = {rem_reg[k-1], bits_reg[k-1][DIV_Q_BITS-1]};
            if (sh[k] >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = DIV_DEN_BITS'(sh[k] - {1'b0, den_reg[k-1]});
                q_next[k]   = {q_reg[k-1][DIV_Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = sh[k][DIV_DEN_BITS-1:0];
                q_next[k]   = {q_reg[k-1][DIV_Q_BITS-2:0], 1'b0};
            end
        end
    end

    // limit is 2^31 for a negative quotient, 2^31-1 otherwise
    always_comb
    begin
        neg_last = neg_reg[DIV_Q_BITS];
        q_lim    = {{(DIV_Q_BITS-WORD_BITS){1'b0}}, neg_last, {(WORD_BITS-1){~neg_last}}};
        if (ovf_reg[DIV_Q_BITS] || (q_reg[DIV_Q_BITS] > q_lim))
            q_sat = q_lim;
        else
            q_sat = q_reg[DIV_Q_BITS];
        quot_next = neg_last ? -$signed(q_sat[WORD_BITS-1:0]) : $signed(q_sat[WORD_BITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_mag[DIV_NUM_BITS-1 -: DIV_DEN_BITS];
        bits_reg[0] <= num_mag[DIV_Q_BITS-1:0];
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        neg_reg[0]  <= num_neg;
        ovf_reg[0]  <= (num_mag[DIV_NUM_BITS-1 -: DIV_DEN_BITS] >= den);
        for (int k = 1; k < DIV_Q_BITS; k++)
        begin
            bits_reg[k] <= {bits_reg[k-1][DIV_Q_BITS-2:0], 1'b0};
        end
        for (int k = 1; k <= DIV_Q_BITS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

[rtl/core/particle_pair_collision.sv]
// One item per cycle is accepted while busy is low; busy is high in reset and, once it
// has dropped, stays low.
// Most of the pipeline depth lies in two rows of 33-stage dividers and the 34-stage square root.
// Mode is sampled with each item; the receiver cannot stall, results are never held.
// Reset clears the pipeline valid bits and sets the mode to elastic.
module particle_pair_collision
    import ppc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pair_t                pair,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MODE_BITS-1:0] cfg_data
);

    localparam int LATENCY = 3 + SQ_LAT + 2 * DIV_LAT + 9;
    localparam int PW = 2 * WORD_BITS;

    typedef struct packed {
        logic                        valid;
        logic [MODE_BITS-1:0]        mode;
        logic                        fault;
        logic [WORD_BITS:0]          msum;
        logic                        dx_neg;
        logic                        dy_neg;
        logic [WORD_BITS:0]          dx_mag;
        logic [WORD_BITS:0]          dy_mag;
        logic [RAD_BITS-1:0]         rad;
        logic signed [WORD_BITS-1:0] nx;
        logic signed [WORD_BITS-1:0] ny;
        logic signed [WORD_BITS-1:0] vin;
        logic signed [WORD_BITS-1:0] vim;
        logic signed [WORD_BITS-1:0] vjn;
        logic signed [WORD_BITS-1:0] vjm;
        pair_t                       pair;
    } ctx_t;

    function automatic logic signed [WORD_BITS-1:0] shr_sat(input logic signed [PW:0] s);
        logic [PW:0]                mag;
        logic [PW-FRAC_BITS:0]      q;
        logic [PW-FRAC_BITS:0]      lim;
        mag = s[PW] ? (PW+1)'(-s) : (PW+1)'(s);
        q   = mag[PW:FRAC_BITS];
        lim = {{(PW-FRAC_BITS+1-WORD_BITS){1'b0}}, s[PW], {(WORD_BITS-1){~s[PW]}}};
        if (q > lim)
            q = lim;
        return s[PW] ? -$signed(q[WORD_BITS-1:0]) : $signed(q[WORD_BITS-1:0]);
    endfunction

    function automatic logic [WORD_BITS-1:0] mass_sat(input logic [WORD_BITS:0] m);
        return m[WORD_BITS] ? '1 : m[WORD_BITS-1:0];
    endfunction

    logic                 ready_reg;
    logic [MODE_BITS-1:0] mode_reg;

    ctx_t c0_reg, c1_reg, c2_reg;
    ctx_t c0_next, c1_next;
    ctx_t sq_pipe_reg [0:SQ_LAT-1];
    ctx_t d1_pipe_reg [0:DIV_LAT-1];
    ctx_t d2_pipe_reg [0:DIV_LAT-1];
    ctx_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    ctx_t cq, cd, ce;
    ctx_t r1_reg, r2_reg;
    ctx_t p3_next;

    logic [2*WORD_BITS+1:0] sqx_reg, sqy_reg;
    logic [SQ_IN_BITS-1:0]  radicand;
    logic [SQ_OUT_BITS-1:0] root;

    logic signed [WORD_BITS-1:0] nx_q, ny_q;
    logic signed [PW-1:0]        pv_reg [0:7];
    logic signed [PW:0]          sv_reg [0:3];

    logic signed [WORD_BITS+2:0]  op_a [0:3];
    logic signed [WORD_BITS+2:0]  op_c [0:3];
    logic signed [WORD_BITS-1:0]  op_b [0:3];
    logic signed [WORD_BITS-1:0]  op_d [0:3];
    logic signed [WORD_BITS+2:0]  smi, smj;
    logic signed [DIV_NUM_BITS-1:0] pa_reg [0:3];
    logic signed [DIV_NUM_BITS-1:0] pc_reg [0:3];
    logic signed [DIV_NUM_BITS:0]   sum_reg [0:3];
    logic [3:0]                     dneg_reg;
    logic [DIV_NUM_BITS-1:0]        dmag_reg [0:3];
    logic signed [WORD_BITS-1:0]    q2 [0:3];

    logic signed [PW-1:0]        rp_reg [0:7];
    logic signed [PW:0]          rs_reg [0:3];
    logic signed [WORD_BITS-1:0] aq1_reg [0:3];
    logic signed [WORD_BITS-1:0] aq2_reg [0:3];

    logic    done_reg;
    result_t result_reg, result_next;

    logic signed [WORD_BITS:0] dx, dy;

    assign busy      = ~ready_reg;
    assign cfg_ready = ready_reg;
    assign done      = done_reg;
    assign result    = result_reg;

    // entry and geometry
    always_comb
    begin
        c0_next       = '0;
        c0_next.valid = start && ready_reg;
        c0_next.mode  = mode_reg;
        c0_next.pair  = pair;

        c1_next        = c0_reg;
        dx             = (WORD_BITS+1)'(c0_reg.pair.in_pos_j_x) - (WORD_BITS+1)'(c0_reg.pair.in_pos_i_x);
        dy             = (WORD_BITS+1)'(c0_reg.pair.in_pos_j_y) - (WORD_BITS+1)'(c0_reg.pair.in_pos_i_y);
        c1_next.dx_neg = dx[WORD_BITS];
        c1_next.dy_neg = dy[WORD_BITS];
        c1_next.dx_mag = dx[WORD_BITS] ? -dx : dx;
        c1_next.dy_mag = dy[WORD_BITS] ? -dy : dy;
        c1_next.msum   = {1'b0, c0_reg.pair.in_mass_i} + {1'b0, c0_reg.pair.in_mass_j};
        c1_next.fault  = ((dx == '0) && (dy == '0)) ||
                         (({1'b0, c0_reg.pair.in_mass_i} + {1'b0, c0_reg.pair.in_mass_j}) == '0);
    end

    // adhesion reuses the root for the merged radius
    always_comb
    begin
        if (c2_reg.mode == MODE_ADHESION)
            radicand = SQ_IN_BITS'({mass_sat(c2_reg.msum), {FRAC_BITS{1'b0}}});
        else
            radicand = SQ_IN_BITS'(sqx_reg) + SQ_IN_BITS'(sqy_reg);
    end

    ppc_isqrt u_isqrt (
        .clk      (clk),
        .radicand (radicand),
        .root     (root)
    );

    always_comb
    begin
        cq = sq_pipe_reg[SQ_LAT-1];
        if (root > SQ_OUT_BITS'(RAD_MAX))
            cq.rad = RAD_MAX;
        else
            cq.rad = root[RAD_BITS-1:0];
    end

    ppc_div u_div_nx (
        .clk     (clk),
        .num_neg (cq.dx_neg),
        .num_mag (DIV_NUM_BITS'({cq.dx_mag, {FRAC_BITS{1'b0}}})),
        .den     (DIV_DEN_BITS'(root)),
        .quot    (nx_q)
    );

    ppc_div u_div_ny (
        .clk     (clk),
        .num_neg (cq.dy_neg),
        .num_mag (DIV_NUM_BITS'({cq.dy_mag, {FRAC_BITS{1'b0}}})),
        .den     (DIV_DEN_BITS'(root)),
        .quot    (ny_q)
    );

    always_comb
    begin
        cd    = d1_pipe_reg[DIV_LAT-1];
        cd.nx = nx_q;
        cd.ny = ny_q;
    end

    always_comb
    begin
        p3_next     = p2_reg;
        p3_next.vin = shr_sat(sv_reg[0]);
        p3_next.vim = shr_sat(sv_reg[1]);
        p3_next.vjn = shr_sat(sv_reg[2]);
        p3_next.vjm = shr_sat(sv_reg[3]);
    end

    // operand selection for the mass-weighted sums
    always_comb
    begin
        smi = $signed({3'b000, p3_reg.pair.in_mass_i});
        smj = $signed({3'b000, p3_reg.pair.in_mass_j});
        for (int l = 0; l < 4; l++)
        begin
            op_a[l] = smi;
            op_c[l] = smj;
        end
        op_b[2] = p3_reg.pair.in_pos_i_x;
        op_d[2] = p3_reg.pair.in_pos_j_x;
        op_b[3] = p3_reg.pair.in_pos_i_y;
        op_d[3] = p3_reg.pair.in_pos_j_y;
        if (p3_reg.mode == MODE_ADHESION)
        begin
            op_b[0] = p3_reg.pair.in_vel_i_x;
            op_d[0] = p3_reg.pair.in_vel_j_x;
            op_b[1] = p3_reg.pair.in_vel_i_y;
            op_d[1] = p3_reg.pair.in_vel_j_y;
        end
        else if (p3_reg.mode == MODE_ELASTIC)
        begin
            op_a[0] = smi - smj;
            op_b[0] = p3_reg.vin;
            op_c[0] = smj <<< 1;
            op_d[0] = p3_reg.vjn;
            op_a[1] = smj - smi;
            op_b[1] = p3_reg.vjn;
            op_c[1] = smi <<< 1;
            op_d[1] = p3_reg.vin;
        end
        else
        begin
            op_b[0] = p3_reg.vin;
            op_d[0] = p3_reg.vjn;
            op_b[1] = p3_reg.vin;
            op_d[1] = p3_reg.vjn;
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        ppc_div u_div_m (
            .clk     (clk),
            .num_neg (dneg_reg[l]),
            .num_mag (dmag_reg[l]),
            .den     (DIV_DEN_BITS'(p6_reg.msum)),
            .quot    (q2[l])
        );
    end

    assign ce = d2_pipe_reg[DIV_LAT-1];

    always_comb
    begin
        result_next              = '0;
        result_next.out_vel_i_x  = r2_reg.pair.in_vel_i_x;
        result_next.out_vel_i_y  = r2_reg.pair.in_vel_i_y;
        result_next.out_vel_j_x  = r2_reg.pair.in_vel_j_x;
        result_next.out_vel_j_y  = r2_reg.pair.in_vel_j_y;
        result_next.out_pos_i_x  = r2_reg.pair.in_pos_i_x;
        result_next.out_pos_i_y  = r2_reg.pair.in_pos_i_y;
        result_next.out_mass_i   = r2_reg.pair.in_mass_i;
        result_next.out_mass_j   = r2_reg.pair.in_mass_j;
        result_next.out_radius_i = r2_reg.pair.in_radius_i;
        result_next.out_radius_j = r2_reg.pair.in_radius_j;
        if (r2_reg.mode <= MODE_ADHESION)
        begin
            if (r2_reg.fault)
            begin
                result_next.fault = 1'b1;
            end
            else if (r2_reg.mode == MODE_ADHESION)
            begin
                result_next.out_vel_i_x  = aq2_reg[0];
                result_next.out_vel_i_y  = aq2_reg[1];
                result_next.out_pos_i_x  = aq2_reg[2];
                result_next.out_pos_i_y  = aq2_reg[3];
                result_next.out_vel_j_x  = '0;
                result_next.out_vel_j_y  = '0;
                result_next.out_mass_i   = mass_sat(r2_reg.msum);
                result_next.out_mass_j   = '0;
                result_next.out_radius_i = r2_reg.rad;
                result_next.out_radius_j = '0;
            end
            else
            begin
                result_next.out_vel_i_x = shr_sat(rs_reg[0]);
                result_next.out_vel_i_y = shr_sat(rs_reg[1]);
                result_next.out_vel_j_x = shr_sat(rs_reg[2]);
                result_next.out_vel_j_y = shr_sat(rs_reg[3]);
            end
        end
    end

    // control and item context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            mode_reg  <= MODE_ELASTIC;
            c0_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            for (int k = 0; k < SQ_LAT; k++)
                sq_pipe_reg[k] <= '0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                d1_pipe_reg[k] <= '0;
                d2_pipe_reg[k] <= '0;
            end
            p1_reg   <= '0;
            p2_reg   <= '0;
            p3_reg   <= '0;
            p4_reg   <= '0;
            p5_reg   <= '0;
            p6_reg   <= '0;
            r1_reg   <= '0;
            r2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
            if (cfg_valid && ready_reg)
                mode_reg <= cfg_data;
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            sq_pipe_reg[0] <= c2_reg;
            for (int k = 1; k < SQ_LAT; k++)
                sq_pipe_reg[k] <= sq_pipe_reg[k-1];
            d1_pipe_reg[0] <= cq;
            d2_pipe_reg[0] <= p6_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                d1_pipe_reg[k] <= d1_pipe_reg[k-1];
                d2_pipe_reg[k] <= d2_pipe_reg[k-1];
            end
            p1_reg   <= cd;
            p2_reg   <= p1_reg;
            p3_reg   <= p3_next;
            p4_reg   <= p3_reg;
            p5_reg   <= p4_reg;
            p6_reg   <= p5_reg;
            r1_reg   <= ce;
            r2_reg   <= r1_reg;
            done_reg <= r2_reg.valid;
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        sqx_reg <= c1_reg.dx_mag * c1_reg.dx_mag;
        sqy_reg <= c1_reg.dy_mag * c1_reg.dy_mag;

        pv_reg[0] <= cd.pair.in_vel_i_x * nx_q;
        pv_reg[1] <= cd.pair.in_vel_i_y * ny_q;
        pv_reg[2] <= cd.pair.in_vel_i_x * ny_q;
        pv_reg[3] <= cd.pair.in_vel_i_y * nx_q;
        pv_reg[4] <= cd.pair.in_vel_j_x * nx_q;
        pv_reg[5] <= cd.pair.in_vel_j_y * ny_q;
        pv_reg[6] <= cd.pair.in_vel_j_x * ny_q;
        pv_reg[7] <= cd.pair.in_vel_j_y * nx_q;

        sv_reg[0] <= (PW+1)'(pv_reg[0]) + (PW+1)'(pv_reg[1]);
        sv_reg[1] <= (PW+1)'(pv_reg[2]) - (PW+1)'(pv_reg[3]);
        sv_reg[2] <= (PW+1)'(pv_reg[4]) + (PW+1)'(pv_reg[5]);
        sv_reg[3] <= (PW+1)'(pv_reg[6]) - (PW+1)'(pv_reg[7]);

        for (int l = 0; l < 4; l++)
        begin
            pa_reg[l]   <= DIV_NUM_BITS'(op_a[l]) * DIV_NUM_BITS'(op_b[l]);
            pc_reg[l]   <= DIV_NUM_BITS'(op_c[l]) * DIV_NUM_BITS'(op_d[l]);
            sum_reg[l]  <= (DIV_NUM_BITS+1)'(pa_reg[l]) + (DIV_NUM_BITS+1)'(pc_reg[l]);
            dneg_reg[l] <= sum_reg[l][DIV_NUM_BITS];
            dmag_reg[l] <= sum_reg[l][DIV_NUM_BITS] ? DIV_NUM_BITS'(-sum_reg[l])
                                                    : DIV_NUM_BITS'(sum_reg[l]);
            aq1_reg[l]  <= q2[l];
            aq2_reg[l]  <= aq1_reg[l];
        end

        rp_reg[0] <= ce.nx * q2[0];
        rp_reg[1] <= ce.ny * ce.vim;
        rp_reg[2] <= ce.ny * q2[0];
        rp_reg[3] <= ce.nx * ce.vim;
        rp_reg[4] <= ce.nx * q2[1];
        rp_reg[5] <= ce.ny * ce.vjm;
        rp_reg[6] <= ce.ny * q2[1];
        rp_reg[7] <= ce.nx * ce.vjm;

        rs_reg[0] <= (PW+1)'(rp_reg[0]) + (PW+1)'(rp_reg[1]);
        rs_reg[1] <= (PW+1)'(rp_reg[2]) - (PW+1)'(rp_reg[3]);
        rs_reg[2] <= (PW+1)'(rp_reg[4]) + (PW+1)'(rp_reg[5]);
        rs_reg[3] <= (PW+1)'(rp_reg[6]) - (PW+1)'(rp_reg[7]);

        result_reg <= result_next;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not complete at the expected latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done strobe without a matching accepted item");

    a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault) |-> ($past(r2_reg.mode) <= MODE_ADHESION))
        else $error("fault flagged in the unused mode");

    a_ready_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after reset");

endmodule

[dv/ppc_checker.sv]
module ppc_checker
    import ppc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  pair_t                pair,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [MODE_BITS-1:0] cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    localparam wide_t UNIT   = wide_t'(1) <<< FRAC_BITS;
    localparam wide_t SW_MAX = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    localparam wide_t SW_MIN = -(wide_t'(1) <<< (WORD_BITS - 1));

    logic [MODE_BITS-1:0] mode_q;
    result_t              expected_q[$];

    function automatic logic signed [WORD_BITS-1:0] sat_div(wide_t num, wide_t den);
        wide_t q;
        q = num / den;
        if (q > SW_MAX)
            q = SW_MAX;
        else if (q < SW_MIN)
            q = SW_MIN;
        return q[WORD_BITS-1:0];
    endfunction

    function automatic wide_t wsum(wide_t a, wide_t b, wide_t c, wide_t d, wide_t den);
        return sat_div(a * b + c * d, den);
    endfunction

    function automatic wide_t isqrt(wide_t v);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 62; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic result_t resolve(pair_t p, logic [MODE_BITS-1:0] mode);
        result_t r;
        wide_t pix, piy, vix, viy, pjx, pjy, vjx, vjy, mi, mj, m, dx, dy;
        wide_t len, nx, ny, vin, vim, vjn, vjm, ni, nj, msat, rad;
        r.out_vel_i_x  = p.in_vel_i_x;
        r.out_vel_i_y  = p.in_vel_i_y;
        r.out_vel_j_x  = p.in_vel_j_x;
        r.out_vel_j_y  = p.in_vel_j_y;
        r.out_pos_i_x  = p.in_pos_i_x;
        r.out_pos_i_y  = p.in_pos_i_y;
        r.out_mass_i   = p.in_mass_i;
        r.out_mass_j   = p.in_mass_j;
        r.out_radius_i = p.in_radius_i;
        r.out_radius_j = p.in_radius_j;
        r.fault        = 1'b0;
        pix = p.in_pos_i_x;
        piy = p.in_pos_i_y;
        vix = p.in_vel_i_x;
        viy = p.in_vel_i_y;
        pjx = p.in_pos_j_x;
        pjy = p.in_pos_j_y;
        vjx = p.in_vel_j_x;
        vjy = p.in_vel_j_y;
        mi  = {96'd0, p.in_mass_i};
        mj  = {96'd0, p.in_mass_j};
        if (mode > MODE_ADHESION)
            return r;
        dx = pjx - pix;
        dy = pjy - piy;
        m  = mi + mj;
        if ((dx == 0 && dy == 0) || m == 0)
        begin
            r.fault = 1'b1;
        end
        else if (mode == MODE_ADHESION)
        begin
            r.out_vel_i_x = wsum(mi, vix, mj, vjx, m);
            r.out_vel_i_y = wsum(mi, viy, mj, vjy, m);
            r.out_pos_i_x = wsum(mi, pix, mj, pjx, m);
            r.out_pos_i_y = wsum(mi, piy, mj, pjy, m);
            r.out_vel_j_x = '0;
            r.out_vel_j_y = '0;
            msat = (m > 128'hFFFF_FFFF) ? 128'hFFFF_FFFF : m;
            r.out_mass_i = msat[WORD_BITS-1:0];
            rad = isqrt(msat * UNIT);
            r.out_radius_i = (rad > {104'd0, RAD_MAX}) ? RAD_MAX : rad[RAD_BITS-1:0];
            r.out_mass_j   = '0;
            r.out_radius_j = '0;
        end
        else
        begin
            len = isqrt(dx * dx + dy * dy);
            nx  = sat_div(dx * UNIT, len);
            ny  = sat_div(dy * UNIT, len);
            vin = wsum(vix, nx, viy, ny, UNIT);
            vim = wsum(vix, ny, viy, -nx, UNIT);
            vjn = wsum(vjx, nx, vjy, ny, UNIT);
            vjm = wsum(vjx, ny, vjy, -nx, UNIT);
            if (mode == MODE_ELASTIC)
            begin
                ni = wsum(mi - mj, vin, 2 * mj, vjn, m);
                nj = wsum(mj - mi, vjn, 2 * mi, vin, m);
            end
            else
            begin
                ni = wsum(mi, vin, mj, vjn, m);
                nj = ni;
            end
            r.out_vel_i_x = wsum(nx, ni, ny, vim, UNIT);
            r.out_vel_i_y = wsum(ny, ni, -nx, vim, UNIT);
            r.out_vel_j_x = wsum(nx, nj, ny, vjm, UNIT);
            r.out_vel_j_y = wsum(ny, nj, -nx, vjm, UNIT);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $realtime, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            mode_q <= MODE_ELASTIC;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_q <= cfg_data;
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no item outstanding", $realtime);
                end
                else
                begin
                    e = expected_q.pop_front();
                    checked++;
                    check_field("vel_i_x", e.out_vel_i_x, result.out_vel_i_x);
                    check_field("vel_i_y", e.out_vel_i_y, result.out_vel_i_y);
                    check_field("vel_j_x", e.out_vel_j_x, result.out_vel_j_x);
                    check_field("vel_j_y", e.out_vel_j_y, result.out_vel_j_y);
                    check_field("pos_i_x", e.out_pos_i_x, result.out_pos_i_x);
                    check_field("pos_i_y", e.out_pos_i_y, result.out_pos_i_y);
                    check_field("mass_i", e.out_mass_i, result.out_mass_i);
                    check_field("mass_j", e.out_mass_j, result.out_mass_j);
                    check_field("radius_i", 32'(e.out_radius_i), 32'(result.out_radius_i));
                    check_field("radius_j", 32'(e.out_radius_j), 32'(result.out_radius_j));
                    check_field("fault", 32'(e.fault), 32'(result.fault));
                end
            end
            if (start && !busy)
                expected_q.push_back(resolve(pair, mode_q));
            pending = expected_q.size();
        end
    end

endmodule

[dv/tb.sv]
module tb;
    import ppc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pair_t                pair;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MODE_BITS-1:0] cfg_data;
    int                   mismatches;
    int                   pending;
    int                   checked;
    int                   cycles;
    int                   sent;
    int                   idle_pct;

    particle_pair_collision DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pair      (pair),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ppc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pair       (pair),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(1, 1 << 22);
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        p.in_pos_i_x  = pick_word();
        p.in_pos_i_y  = pick_word();
        p.in_vel_i_x  = pick_word();
        p.in_vel_i_y  = pick_word();
        p.in_mass_i   = pick_mass();
        p.in_radius_i = RAD_BITS'($urandom);
        p.in_vel_j_x  = pick_word();
        p.in_vel_j_y  = pick_word();
        p.in_mass_j   = pick_mass();
        p.in_radius_j = RAD_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                p.in_pos_j_x = p.in_pos_i_x;
                p.in_pos_j_y = p.in_pos_i_y;
            end
            1, 2:
            begin
                p.in_pos_j_x = pick_word();
                p.in_pos_j_y = pick_word();
            end
            default:
            begin
                // touching pairs: centres a short distance apart
                p.in_pos_j_x = p.in_pos_i_x + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                p.in_pos_j_y = p.in_pos_i_y + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            end
        endcase
        return p;
    endfunction

    task automatic send_item(pair_t p);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        pair  <= p;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
    endtask

    task automatic write_mode(logic [MODE_BITS-1:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_set();
        pair_t p;
        p = '0;
        p.in_pos_j_x = 32'h0001_0000;
        p.in_mass_i  = 32'h0001_0000;
        p.in_mass_j  = 32'h0002_0000;
        p.in_vel_i_x = 32'h0003_0000;
        p.in_vel_j_x = 32'hFFFE_0000;
        p.in_vel_i_y = 32'h0000_8000;
        send_item(p);
        p.in_pos_j_x = p.in_pos_i_x;
        send_item(p);                   // coincident centres
        p.in_pos_j_y = 32'h0000_0100;
        p.in_mass_i  = '0;
        p.in_mass_j  = '0;
        send_item(p);                   // zero total mass
        p.in_pos_i_x = 32'h8000_0000;
        p.in_pos_i_y = 32'h8000_0000;
        p.in_pos_j_x = 32'h7FFF_FFFF;
        p.in_pos_j_y = 32'h7FFF_FFFF;
        p.in_vel_i_x = 32'h7FFF_FFFF;
        p.in_vel_i_y = 32'h8000_0000;
        p.in_vel_j_x = 32'h8000_0000;
        p.in_vel_j_y = 32'h7FFF_FFFF;
        p.in_mass_i  = 32'hFFFF_FFFF;
        p.in_mass_j  = 32'hFFFF_FFFF;
        p.in_radius_i = RAD_MAX;
        p.in_radius_j = RAD_MAX;
        send_item(p);                   // full-scale, merged mass saturates
        p.in_mass_j  = '0;
        p.in_pos_j_x = 32'h8000_0001;
        p.in_pos_j_y = 32'h8000_0000;
        send_item(p);
        send_item('1);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pair      = '0;
        cfg_valid = 1'b0;
        cfg_data  = MODE_ELASTIC;
        sent      = 0;
        idle_pct  = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int m = 0; m < 4; m++)
        begin
            write_mode(m[MODE_BITS-1:0]);
            directed_set();
            drain();
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 12 : (ph == 1) ? 48 : 0;
            for (int m = 0; m < 4; m++)
            begin
                write_mode(m[MODE_BITS-1:0]);
                repeat (125)
                    send_item(random_pair());
                drain();
            end
        end
        write_mode(MODE_ELASTIC);
        repeat (200)
            @(posedge clk);

        $display("%0d pairs sent across elastic, inelastic, adhesion and unused mode", sent);
        $display("under three pacing profiles; %0d results compared", checked);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ppc_pkg.sv
rtl/core/ppc_isqrt.sv
rtl/core/ppc_div.sv
rtl/core/particle_pair_collision.sv
dv/ppc_checker.sv
dv/tb.sv
